>>> design/tscm_pkg.sv
// Shared constants and types for the two-sigma clipped mean block.
package tscm_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int VALUE_W         = 16;   // width of the sample port
    localparam int GAP_W           = 16;   // width of the gap result
    localparam int BOUND_SHIFT     = 2;    // (2 sigma)^2 = 4 * variance

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_S2,
        ST_NQ_LO,
        ST_NQ_HI,
        ST_BOUND,
        ST_BOUND2,
        ST_RD,
        ST_NV,
        ST_DIFF,
        ST_DSQ,
        ST_CMP,
        ST_DIV,
        ST_DIVW,
        ST_OUT
    } t_state;

endpackage

>>> design/two_sigma_clipped_mean.sv
// Samples load at one per cycle while the block is idle (store write, running sums).
// On a closing item, S^2 and n*Q are formed on the shared multiplier, then each stored
// sample visits the shared multiplier and store read port in turn, then a bit-serial
// divider averages the kept samples. No input is taken meanwhile.
// Reset clears count, sums, drop flag, held gap and output valid; store is not cleared.
module two_sigma_clipped_mean #(
    parameter int MAX_SAMPLES = tscm_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = tscm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [tscm_pkg::VALUE_W-1:0] i_sample_value,
    input  logic                         i_has_sample,
    input  logic                         i_last_sample,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [tscm_pkg::GAP_W-1:0]   o_gap_distance,
    output logic                         o_updated,
    output logic                         o_overflowed
);

    localparam int SW   = (SAMPLE_BITS < tscm_pkg::VALUE_W) ? SAMPLE_BITS : tscm_pkg::VALUE_W;
    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int SUMW = SW + CW;
    localparam int QW   = 2 * SW + CW;
    localparam int PW   = 2 * SUMW;
    localparam int BW   = PW + tscm_pkg::BOUND_SHIFT;
    localparam int GW   = tscm_pkg::GAP_W;

    tscm_pkg::t_state r_state, n_state;

    logic [CW-1:0]   r_count;
    logic [SUMW-1:0] r_sum;
    logic [QW-1:0]   r_q;
    logic [2*SW-1:0] r_sq;
    logic            r_sq_vld;
    logic            r_drop;
    logic [GW-1:0]   r_kept_gap;

    logic [PW-1:0]   r_s2;
    logic [PW-1:0]   r_nq;
    logic [BW-1:0]   r_bound;
    logic [CW-1:0]   r_idx;
    logic [SW-1:0]   r_v;
    logic [SUMW-1:0] r_d;
    logic [SUMW-1:0] r_kept_sum;
    logic [CW-1:0]   r_kept_num;
    logic [GW-1:0]   r_gap_new;
    logic            r_upd;

    logic            r_out_valid;
    logic [GW-1:0]   r_out_gap;
    logic            r_out_upd;
    logic            r_out_ovf;

    logic            in_acc;
    logic            store_wr;
    logic [SW-1:0]   in_v;
    logic [SW-1:0]   rd_data;
    logic [SUMW-1:0] mul_a;
    logic [SUMW-1:0] mul_b;
    logic [PW-1:0]   mul_p;
    logic [SUMW-1:0] nv;
    logic            div_start;
    logic            div_done;
    logic [SUMW-1:0] div_quo;
    logic            out_load;
    logic            last_idx;

    assign o_in_ready = (r_state == tscm_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_v       = i_sample_value[SW-1:0];
    assign store_wr   = in_acc && i_has_sample && (r_count < CW'(MAX_SAMPLES));
    assign nv         = mul_p[SUMW-1:0];
    assign last_idx   = ((r_idx + 1'b1) == r_count);
    assign out_load   = (r_state == tscm_pkg::ST_OUT) && (!r_out_valid || i_out_ready);

    tscm_store #(
        .DEPTH (MAX_SAMPLES),
        .DW    (SW),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (store_wr),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (in_v),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    tscm_mul #(
        .W (SUMW)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    tscm_div #(
        .DIVIDEND_W (SUMW),
        .DIVISOR_W  (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_kept_sum),
        .i_divisor  (r_kept_num),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tscm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, multiplier operand select, divider start
    always_comb begin
        n_state   = r_state;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        case (r_state)
            tscm_pkg::ST_IDLE: begin
                if (in_acc && i_last_sample) begin
                    n_state = tscm_pkg::ST_S2;
                end
            end
            tscm_pkg::ST_S2: begin
                mul_a   = r_sum;
                mul_b   = r_sum;
                n_state = tscm_pkg::ST_NQ_LO;
            end
            tscm_pkg::ST_NQ_LO: begin
                mul_a   = SUMW'(r_count);
                mul_b   = r_q[SUMW-1:0];
                n_state = tscm_pkg::ST_NQ_HI;
            end
            tscm_pkg::ST_NQ_HI: begin
                mul_a   = SUMW'(r_count);
                mul_b   = SUMW'(r_q[QW-1:SUMW]);
                n_state = tscm_pkg::ST_BOUND;
            end
            tscm_pkg::ST_BOUND: begin
                n_state = tscm_pkg::ST_BOUND2;
            end
            tscm_pkg::ST_BOUND2: begin
                n_state = (r_count == '0) ? tscm_pkg::ST_DIV : tscm_pkg::ST_RD;
            end
            tscm_pkg::ST_RD: begin
                n_state = tscm_pkg::ST_NV;
            end
            tscm_pkg::ST_NV: begin
                mul_a   = SUMW'(r_count);
                mul_b   = SUMW'(rd_data);
                n_state = tscm_pkg::ST_DIFF;
            end
            tscm_pkg::ST_DIFF: begin
                n_state = tscm_pkg::ST_DSQ;
            end
            tscm_pkg::ST_DSQ: begin
                mul_a   = r_d;
                mul_b   = r_d;
                n_state = tscm_pkg::ST_CMP;
            end
            tscm_pkg::ST_CMP: begin
                n_state = last_idx ? tscm_pkg::ST_DIV : tscm_pkg::ST_RD;
            end
            tscm_pkg::ST_DIV: begin
                if (r_kept_num == '0) begin
                    n_state = tscm_pkg::ST_OUT;
                end else begin
                    div_start = 1'b1;
                    n_state   = tscm_pkg::ST_DIVW;
                end
            end
            tscm_pkg::ST_DIVW: begin
                if (div_done) begin
                    n_state = tscm_pkg::ST_OUT;
                end
            end
            tscm_pkg::ST_OUT: begin
                if (out_load) begin
                    n_state = tscm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tscm_pkg::ST_IDLE;
            end
        endcase
    end

    // set statistics and held gap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_sum      <= '0;
            r_q        <= '0;
            r_sq_vld   <= 1'b0;
            r_drop     <= 1'b0;
            r_kept_gap <= '0;
        end else begin
            r_sq_vld <= store_wr;
            if (store_wr) begin
                r_count <= r_count + 1'b1;
                r_sum   <= r_sum + SUMW'(in_v);
            end
            if (in_acc && i_has_sample && !store_wr) begin
                r_drop <= 1'b1;
            end
            // square is registered and lands in the cycle after the sample; done before n*Q is formed
            if (r_sq_vld) begin
                r_q <= r_q + QW'(r_sq);
            end
            if (out_load) begin
                r_count    <= '0;
                r_sum      <= '0;
                r_q        <= '0;
                r_drop     <= 1'b0;
                r_kept_gap <= r_gap_new;
            end
        end
    end

    // closing walk datapath
    always_ff @(posedge i_clk) begin
        r_sq <= (2*SW)'(in_v) * (2*SW)'(in_v);
        case (r_state)
            tscm_pkg::ST_NQ_LO: begin
                r_s2 <= mul_p;
            end
            tscm_pkg::ST_NQ_HI: begin
                r_nq <= mul_p;
            end
            tscm_pkg::ST_BOUND: begin
                r_nq <= r_nq + (mul_p << SUMW);
            end
            tscm_pkg::ST_BOUND2: begin
                r_bound    <= BW'(r_nq - r_s2) << tscm_pkg::BOUND_SHIFT;
                r_idx      <= '0;
                r_kept_sum <= '0;
                r_kept_num <= '0;
            end
            tscm_pkg::ST_NV: begin
                r_v <= rd_data;
            end
            tscm_pkg::ST_DIFF: begin
                r_d <= (nv >= r_sum) ? (nv - r_sum) : (r_sum - nv);
            end
            tscm_pkg::ST_CMP: begin
                if (BW'(mul_p) <= r_bound) begin
                    r_kept_sum <= r_kept_sum + SUMW'(r_v);
                    r_kept_num <= r_kept_num + 1'b1;
                end
                r_idx <= r_idx + 1'b1;
            end
            tscm_pkg::ST_DIV: begin
                r_gap_new <= r_kept_gap;
                r_upd     <= 1'b0;
            end
            tscm_pkg::ST_DIVW: begin
                if (div_done) begin
                    r_gap_new <= GW'(div_quo);
                    r_upd     <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_gap <= r_gap_new;
            r_out_upd <= r_upd;
            r_out_ovf <= r_drop;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_gap_distance = r_out_gap;
    assign o_updated      = r_out_upd;
    assign o_overflowed   = r_out_ovf;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SAMPLES))
        else $error("sample count beyond store depth");

    a_variance_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tscm_pkg::ST_BOUND2) |-> (r_nq >= r_s2))
        else $error("n*Q below S^2");

    a_kept_le_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tscm_pkg::ST_CMP) |-> (r_kept_num <= r_idx))
        else $error("kept count ahead of walk index");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_kept_num != '0))
        else $error("divide by zero started");

    a_set_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_count == '0 && r_sum == '0 && !r_drop && o_out_valid))
        else $error("set not cleared after result");
`endif

endmodule

>>> design/tscm_store.sv
// Sample store: one write port, one read port with registered read data.
module tscm_store #(
    parameter int DEPTH = tscm_pkg::MAX_SAMPLES_DEF,
    parameter int DW    = tscm_pkg::SAMPLE_BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/tscm_mul.sv
// Shared multiplier with registered product.
module tscm_mul #(
    parameter int W = 26
) (
    input  logic           i_clk,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic [2*W-1:0] o_p
);

    logic [2*W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= (2*W)'(i_a) * (2*W)'(i_b);
    end

    assign o_p = r_p;

endmodule

>>> design/tscm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module tscm_div #(
    parameter int DIVIDEND_W = 26,
    parameter int DIVISOR_W  = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    trial;
    logic                  q_bit;
    logic [DIVISOR_W-1:0]  n_rem;
    logic [DIVIDEND_W-1:0] n_quo;

    always_comb begin
        shifted = {r_rem, r_quo[DIVIDEND_W-1]};
        trial   = shifted - {1'b0, r_dvs};
        q_bit   = (shifted >= {1'b0, r_dvs});
        n_rem   = q_bit ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        n_quo   = {r_quo[DIVIDEND_W-2:0], q_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the two-sigma clipped mean block.
module tb_top;

    localparam int VW          = tscm_pkg::VALUE_W;
    localparam int GW          = tscm_pkg::GAP_W;
    localparam int STORE_DEPTH = tscm_pkg::MAX_SAMPLES_DEF;
    localparam int LONG_HOLD   = 200;
    localparam int TAIL_ITEMS  = 60;
    localparam int RAND_ITEMS  = 400;

    typedef enum int {
        FILL_SPREAD,
        FILL_CLUSTER,
        FILL_FLAT,
        FILL_EXTREME
    } t_fill_style;

    typedef struct packed {
        bit [VW-1:0] value;
        bit          has;
        bit          last;
    } t_sample_txn;

    typedef struct packed {
        bit [GW-1:0] gap;
        bit          updated;
        bit          overflowed;
    } t_gap_result;

    logic          i_clk          = 1'b0;
    logic          i_rst_n        = 1'b0;
    logic          i_in_valid     = 1'b0;
    logic          o_in_ready;
    logic [VW-1:0] i_sample_value = '0;
    logic          i_has_sample   = 1'b0;
    logic          i_last_sample  = 1'b0;
    logic          o_out_valid;
    logic          i_out_ready    = 1'b0;
    logic [GW-1:0] o_gap_distance;
    logic          o_updated;
    logic          o_overflowed;

    two_sigma_clipped_mean i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_value (i_sample_value),
        .i_has_sample   (i_has_sample),
        .i_last_sample  (i_last_sample),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_gap_distance (o_gap_distance),
        .o_updated      (o_updated),
        .o_overflowed   (o_overflowed)
    );

    // predictor state
    bit [VW-1:0]      set_samples[$];
    bit [25:0]        set_sum;
    bit [41:0]        set_square_sum;
    bit [GW-1:0]      held_gap;
    bit               set_dropped;

    t_sample_txn      sample_txns[$];
    t_gap_result      expected_gaps[$];
    int               fail_count   = 0;
    int               results_seen = 0;
    int               gen_items    = 0;
    bit               in_taken     = 1'b0;
    bit               calm         = 1'b0;
    int               in_gap_left  = 0;
    int               out_gap_left = 0;
    int               hold_left    = 0;
    bit               hold_done    = 1'b0;
    bit [VW-1:0]      set_base;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

    // Close the set: keep v iff (n*v - S)^2 <= 4*(n*Q - S^2), average the kept ones.
    function automatic t_gap_result close_set();
        t_gap_result res;
        bit [63:0]   n;
        bit [63:0]   s;
        bit [63:0]   nq;
        bit [63:0]   s2;
        bit [63:0]   bound;
        bit [63:0]   nv;
        bit [63:0]   d;
        bit [63:0]   kept_sum;
        bit [63:0]   kept_num;
        n        = 64'(set_samples.size());
        s        = 64'(set_sum);
        nq       = n * 64'(set_square_sum);
        s2       = s * s;
        bound    = (nq >= s2) ? (nq - s2) << tscm_pkg::BOUND_SHIFT : 64'd0;
        kept_sum = '0;
        kept_num = '0;
        foreach (set_samples[i]) begin
            nv = n * 64'(set_samples[i]);
            d  = (nv >= s) ? nv - s : s - nv;
            if (d * d <= bound) begin
                kept_sum += 64'(set_samples[i]);
                kept_num++;
            end
        end
        if (kept_num != 0) begin
            held_gap    = GW'(kept_sum / kept_num);
            res.updated = 1'b1;
        end else begin
            res.updated = 1'b0;
        end
        res.gap        = held_gap;
        res.overflowed = set_dropped;
        return res;
    endfunction

    task automatic accept_sample(input bit [VW-1:0] v, input bit has, input bit last);
        if (has) begin
            if (set_samples.size() < STORE_DEPTH) begin
                set_samples.insert(set_samples.size(), v);
                set_sum        = set_sum + 26'(v);
                set_square_sum = set_square_sum + 42'(v) * 42'(v);
            end else begin
                set_dropped = 1'b1;
            end
        end
        if (last) begin
            expected_gaps.insert(expected_gaps.size(), close_set());
            set_samples.delete();
            set_sum        = '0;
            set_square_sum = '0;
            set_dropped    = 1'b0;
        end
    endtask

    // monitor: outputs are checked before the new input is predicted
    always @(posedge i_clk) begin : monitor
        t_gap_result exp_res;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_gaps.size() == 0) begin
                    $error("unexpected result: gap_distance=%0d", o_gap_distance);
                    fail_count++;
                end else begin
                    exp_res = expected_gaps.pop_front();
                    if (o_gap_distance !== exp_res.gap) begin
                        $error("gap_distance: expected %0d, actual %0d",
                               exp_res.gap, o_gap_distance);
                        fail_count++;
                    end
                    if (o_updated !== exp_res.updated) begin
                        $error("updated: expected %0d, actual %0d",
                               exp_res.updated, o_updated);
                        fail_count++;
                    end
                    if (o_overflowed !== exp_res.overflowed) begin
                        $error("overflowed: expected %0d, actual %0d",
                               exp_res.overflowed, o_overflowed);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready)
                accept_sample(i_sample_value, i_has_sample, i_last_sample);
            in_taken <= i_in_valid && o_in_ready;
        end else begin
            in_taken <= 1'b0;
        end
    end

    always @(negedge i_clk) begin : driver
        t_sample_txn txn;
        calm = (sample_txns.size() < TAIL_ITEMS);
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (in_gap_left == 0 && sample_txns.size() != 0) begin
                txn = sample_txns.pop_front();
                i_in_valid     <= 1'b1;
                i_sample_value <= txn.value;
                i_has_sample   <= txn.has;
                i_last_sample  <= txn.last;
                if (!calm && $urandom_range(0, 3) == 0)
                    in_gap_left = $urandom_range(1, 3);
            end else begin
                i_in_valid <= 1'b0;
                if (in_gap_left > 0)
                    in_gap_left--;
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        logic ready_nxt;
        ready_nxt = 1'b0;
        if (!i_rst_n) begin
            ready_nxt = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
        end else if (!hold_done && results_seen >= 8) begin
            // long back-pressure so the block fills and stalls its input
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
        end else if (out_gap_left > 0) begin
            out_gap_left--;
        end else begin
            ready_nxt = 1'b1;
            if (!calm && $urandom_range(0, 4) == 0)
                out_gap_left = $urandom_range(1, 3);
        end
        i_out_ready <= ready_nxt;
    end

    task automatic push_txn(input bit [VW-1:0] v, input bit has, input bit last);
        t_sample_txn txn;
        txn.value = v;
        txn.has   = has;
        txn.last  = last;
        sample_txns.insert(sample_txns.size(), txn);
        if (has || last)
            gen_items++;
    endtask

    function automatic bit [VW-1:0] draw_value(input t_fill_style style);
        int unsigned lo;
        int unsigned hi;
        case (style)
            FILL_CLUSTER: begin
                if ($urandom_range(0, 7) == 0)
                    return VW'($urandom_range(0, 65535));
                lo = (set_base > 16'd50) ? 32'(set_base) - 32'd50 : 32'd0;
                hi = (set_base < 16'd65485) ? 32'(set_base) + 32'd50 : 32'd65535;
                return VW'($urandom_range(lo, hi));
            end
            FILL_FLAT:    return set_base;
            FILL_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
            default:      return VW'($urandom_range(0, 65535));
        endcase
    endfunction

    // n samples, closed either on the last sample or by an empty closing transaction
    task automatic push_set(input int n, input t_fill_style style, input bit noise);
        bit close_on_sample;
        set_base        = VW'($urandom_range(0, 65535));
        close_on_sample = (n > 0) && $urandom_range(0, 2) != 0;
        for (int i = 0; i < n; i++) begin
            if (noise && $urandom_range(0, 9) == 0)
                push_txn(VW'($urandom), 1'b0, 1'b0);
            push_txn(draw_value(style), 1'b1, close_on_sample && i == n - 1);
        end
        if (!close_on_sample)
            push_txn(VW'($urandom), 1'b0, 1'b1);
    endtask

    initial begin : stimulus
        bit big_done;
        int n;
        set_samples.delete();
        set_sum        = '0;
        set_square_sum = '0;
        held_gap       = '0;
        set_dropped    = 1'b0;
        big_done       = 1'b0;

        // directed
        push_txn(16'hFFFF, 1'b0, 1'b0);     // ignored
        push_txn(16'h0000, 1'b0, 1'b1);     // empty set, nothing held yet
        push_txn(16'hFFFF, 1'b1, 1'b1);
        push_txn(16'h0000, 1'b0, 1'b1);     // empty set repeats held gap
        push_txn(16'h0000, 1'b1, 1'b1);
        push_txn(16'h0000, 1'b1, 1'b0);
        push_txn(16'hFFFF, 1'b1, 1'b1);
        for (int i = 0; i < 3; i++)
            push_txn(16'd1234, 1'b1, i == 2);   // zero deviation
        for (int i = 0; i < 6; i++)
            push_txn(16'd100 + 16'(i), 1'b1, 1'b0);
        push_txn(16'hAAAA, 1'b0, 1'b0);     // ignored mid-set
        push_txn(16'd60000, 1'b1, 1'b0);    // outlier gets clipped
        push_txn(16'h5555, 1'b0, 1'b1);     // close without a sample
        push_txn(16'h0000, 1'b0, 1'b1);

        gen_items = 0;
        while (gen_items < RAND_ITEMS) begin
            if (!big_done && gen_items >= RAND_ITEMS / 3) begin
                big_done = 1'b1;
                push_set(STORE_DEPTH, FILL_SPREAD, 1'b0);       // exactly full
                push_set(STORE_DEPTH + 5, FILL_CLUSTER, 1'b1);  // drops samples
                gen_items = RAND_ITEMS / 3 + 1;
            end
            case ($urandom_range(0, 15))
                0:       n = 0;
                1:       n = $urandom_range(17, 64);
                default: n = $urandom_range(1, 16);
            endcase
            push_set(n, t_fill_style'($urandom_range(0, 3)), 1'b1);
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (sample_txns.size() != 0 || i_in_valid || expected_gaps.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (fail_count == 0 && expected_gaps.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
design/tscm_pkg.sv
design/tscm_store.sv
design/tscm_mul.sv
design/tscm_div.sv
design/two_sigma_clipped_mean.sv
test/tb_top.sv
